// ===== design/tensor_cell_address_builder_defines.svh =====
// Assertion macros used by the checker file of the tensor cell address builder.
// Depends on nothing; each macro expects signals clk and rst in the using scope.
`ifndef TENSOR_CELL_ADDRESS_BUILDER_DEFINES_SVH
`define TENSOR_CELL_ADDRESS_BUILDER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TCAB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define TCAB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/tcab_pkg.sv =====
// Shared types and codes for the tensor cell address builder.
// Used by the controller, the datapath, the top level and the checker.
package tcab_pkg;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_RANGE  = 3'd1,
    ST_TAKEN  = 3'd2,
    ST_UNDEF  = 3'd3,
    ST_BADDIM = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FINISH
  } state_t;

  localparam logic [2:0] REG_DIM_COUNT = 3'd0;
  localparam logic [2:0] REG_DIM_ORDER = 3'd1;
  localparam logic [2:0] REG_SIZE0     = 3'd2;
  localparam logic [2:0] REG_SIZE1     = 3'd3;
  localparam logic [2:0] REG_SIZE2     = 3'd4;
  localparam logic [2:0] REG_SIZE3     = 3'd5;

  localparam logic [2:0] DIM_COUNT_RST = 3'd1;
  localparam logic [7:0] DIM_ORDER_RST = 8'd228;
  localparam logic [16:0] SIZE_RST     = 17'd1;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;          // capture item, start walk
    logic label_commit;  // check and store label, latch result
    logic walk_step;     // one multiply-add over one position
    logic walk_fail;     // latch label-undefined result
    logic walk_ok;       // latch address write result
    logic publish;       // move latched result to output registers
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_cell;
    logic walk_done;
    logic walk_miss;
  } dp_stat_t;

endpackage

// ===== design/tcab_controller.sv =====
// Sequencer for the tensor cell address builder: accepts an item, drives the
// datapath through label check or address walk, and owns the output handshake. Uses tcab_pkg.
module tcab_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  tcab_pkg::dp_stat_t  stat,
  output tcab_pkg::dp_cmd_t   cmd
);

  tcab_pkg::state_t state, state_next;
  logic out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tcab_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      tcab_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = tcab_pkg::S_EXEC;
        end
      end
      tcab_pkg::S_EXEC: begin
        if (!stat.is_cell) begin
          cmd.label_commit = 1'b1;
          state_next       = tcab_pkg::S_FINISH;
        end else if (stat.walk_done) begin
          cmd.walk_ok = 1'b1;
          state_next  = tcab_pkg::S_FINISH;
        end else if (stat.walk_miss) begin
          cmd.walk_fail = 1'b1;
          state_next    = tcab_pkg::S_FINISH;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      tcab_pkg::S_FINISH: begin
        // hold the result until the output slot frees up
        if (out_free) begin
          cmd.publish = 1'b1;
          state_next  = tcab_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = tcab_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/tcab_datapath.sv =====
// Datapath of the tensor cell address builder: configuration registers, label store,
// shared multiply-add for the address walk, and result/output registers. Uses tcab_pkg.
module tcab_datapath #(
  parameter int MAX_DIMS   = 4,
  parameter int LABEL_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [2:0]          cfg_index,
  input  logic [16:0]         cfg_data,
  input  logic                func,
  input  logic [1:0]          dim_index,
  input  logic [15:0]         label_value,
  input  logic [63:0]         cell_value,
  input  tcab_pkg::dp_cmd_t   cmd,
  output tcab_pkg::dp_stat_t  stat,
  output logic [2:0]          status,
  output logic                write_valid,
  output logic [31:0]         cell_address,
  output logic [63:0]         write_value
);

  localparam int NPOS = (MAX_DIMS < 4) ? MAX_DIMS : 4;
  localparam int LB_W = (LABEL_BITS < 16) ? LABEL_BITS : 16;
  localparam logic [2:0]  NPOS_CNT   = 3'(NPOS);
  localparam logic [15:0] LABEL_MASK = 16'((17'd1 << LB_W) - 17'd1);

  // configuration
  logic [2:0]  dim_count;
  logic [7:0]  dim_order;
  logic [16:0] sizes [4];

  // label store
  logic [LB_W-1:0] labels [NPOS];
  logic [NPOS-1:0] label_set;

  // captured item and walk state
  logic        it_func;
  logic [1:0]  it_dim;
  logic [15:0] it_label;
  logic [63:0] it_value;
  logic [2:0]  walk_k;
  logic [31:0] addr;
  logic [31:0] mult;

  // latched result
  tcab_pkg::status_t res_status;
  logic              res_wvalid;
  logic [31:0]       res_addr;
  logic [63:0]       res_value;

  logic [2:0]        n_dims;
  logic [1:0]        pos;
  logic [1:0]        walk_i;
  logic [1:0]        sel;
  logic [16:0]       size_sel;
  logic              set_sel;
  logic [LB_W-1:0]   lab_sel;
  tcab_pkg::status_t label_code;

  always_comb begin
    if (dim_count == 3'd0) begin
      n_dims = 3'd1;
    end else if (dim_count > 3'd4) begin
      n_dims = 3'd4;
    end else begin
      n_dims = dim_count;
    end
    if (n_dims > NPOS_CNT) begin
      n_dims = NPOS_CNT;
    end
  end

  always_comb begin
    case (it_dim)
      2'd0:    pos = dim_order[1:0];
      2'd1:    pos = dim_order[3:2];
      2'd2:    pos = dim_order[5:4];
      default: pos = dim_order[7:6];
    endcase
  end

  assign walk_i   = 2'(walk_k - 3'd1);
  // one position is looked at per cycle, chosen by item kind
  assign sel      = it_func ? walk_i : pos;
  assign size_sel = sizes[sel];

  always_comb begin
    set_sel = 1'b0;
    lab_sel = '0;
    for (int i = 0; i < NPOS; i++) begin
      if (sel == 2'(i)) begin
        set_sel = label_set[i];
        lab_sel = labels[i];
      end
    end
  end

  always_comb begin
    if ({1'b0, it_dim} >= n_dims || {1'b0, pos} >= n_dims) begin
      label_code = tcab_pkg::ST_BADDIM;
    end else if ({1'b0, it_label} >= size_sel) begin
      label_code = tcab_pkg::ST_RANGE;
    end else if (set_sel) begin
      label_code = tcab_pkg::ST_TAKEN;
    end else begin
      label_code = tcab_pkg::ST_OK;
    end
  end

  assign stat.is_cell   = it_func;
  assign stat.walk_done = (walk_k == 3'd0);
  assign stat.walk_miss = !set_sel;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dim_count <= tcab_pkg::DIM_COUNT_RST;
      dim_order <= tcab_pkg::DIM_ORDER_RST;
      for (int i = 0; i < 4; i++) begin
        sizes[i] <= tcab_pkg::SIZE_RST;
      end
    end else if (cfg_write) begin
      unique case (cfg_index)
        tcab_pkg::REG_DIM_COUNT: dim_count <= cfg_data[2:0];
        tcab_pkg::REG_DIM_ORDER: dim_order <= cfg_data[7:0];
        tcab_pkg::REG_SIZE0:     sizes[0]  <= cfg_data;
        tcab_pkg::REG_SIZE1:     sizes[1]  <= cfg_data;
        tcab_pkg::REG_SIZE2:     sizes[2]  <= cfg_data;
        tcab_pkg::REG_SIZE3:     sizes[3]  <= cfg_data;
        default: ;
      endcase
    end
  end

  // set flags; a label value is only read while its flag is set
  always_ff @(posedge clk) begin
    if (rst) begin
      label_set <= '0;
    end else begin
      for (int i = 0; i < NPOS; i++) begin
        if (cmd.label_commit && label_code == tcab_pkg::ST_OK && pos == 2'(i)) begin
          label_set[i] <= 1'b1;
        end else if (cmd.walk_step && walk_i == 2'(i)) begin
          label_set[i] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NPOS; i++) begin
      if (cmd.label_commit && label_code == tcab_pkg::ST_OK && pos == 2'(i)) begin
        labels[i] <= it_label[LB_W-1:0];
      end
    end
  end

  // item capture, walk and result latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it_func  <= func;
      it_dim   <= dim_index;
      it_label <= label_value & LABEL_MASK;
      it_value <= cell_value;
      walk_k   <= n_dims;
      addr     <= '0;
      mult     <= 32'd1;
    end
    if (cmd.walk_step) begin
      addr   <= addr + 32'(32'(lab_sel) * mult);
      mult   <= 32'(mult * 32'(size_sel));
      walk_k <= walk_k - 3'd1;
    end
    if (cmd.label_commit) begin
      res_status <= label_code;
      res_wvalid <= 1'b0;
      res_addr   <= '0;
      res_value  <= '0;
    end
    if (cmd.walk_fail) begin
      res_status <= tcab_pkg::ST_UNDEF;
      res_wvalid <= 1'b0;
      res_addr   <= '0;
      res_value  <= '0;
    end
    if (cmd.walk_ok) begin
      res_status <= tcab_pkg::ST_OK;
      res_wvalid <= 1'b1;
      res_addr   <= addr;
      res_value  <= it_value;
    end
    if (cmd.publish) begin
      status       <= res_status;
      write_valid  <= res_wvalid;
      cell_address <= res_addr;
      write_value  <= res_value;
    end
  end

endmodule

// ===== design/tensor_cell_address_builder.sv =====
// Top level of the tensor cell address builder: controller plus datapath.
// Depends on tcab_pkg, tcab_controller and tcab_datapath.
//
// Takes one item at a time. A label item is checked in the execute state, and its result
// is published to the output registers from the finish state, after which the next item
// can be taken. A cell item walks over n positions, where n is the active dimension count
// (1..4, capped by MAX_DIMS), one position per cycle through a single shared multiply-add;
// a missing label stops the walk early. A new item is taken once the previous one is
// latched, even while its result still waits on the output side; an item that finishes
// while the output is stalled waits until the output frees up.
// Configuration writes take effect at once and are meant for idle periods only.
module tensor_cell_address_builder #(
  parameter int MAX_DIMS   = 4,
  parameter int LABEL_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [1:0]  dim_index,
  input  logic [15:0] label_value,
  input  logic [63:0] cell_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic        write_valid,
  output logic [31:0] cell_address,
  output logic [63:0] write_value
);

  tcab_pkg::dp_cmd_t  cmd;
  tcab_pkg::dp_stat_t stat;

  tcab_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tcab_datapath #(
    .MAX_DIMS   (MAX_DIMS),
    .LABEL_BITS (LABEL_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .func         (func),
    .dim_index    (dim_index),
    .label_value  (label_value),
    .cell_value   (cell_value),
    .cmd          (cmd),
    .stat         (stat),
    .status       (status),
    .write_valid  (write_valid),
    .cell_address (cell_address),
    .write_value  (write_value)
  );

endmodule

// ===== design/tcab_checker.sv =====
// Port-level checks for the tensor cell address builder, bound to the top level.
// Depends on tcab_pkg and tensor_cell_address_builder_defines.svh.
`include "tensor_cell_address_builder_defines.svh"

module tcab_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic        write_valid,
  input logic [31:0] cell_address,
  input logic [63:0] write_value
);

  `TCAB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(cell_address), "output item changed while stalled")
  `TCAB_ASSERT_NOW(a_write_ok, out_valid && write_valid, status == tcab_pkg::ST_OK, "write emitted with error status")
  `TCAB_ASSERT_NOW(a_status_code, out_valid, status <= tcab_pkg::ST_BADDIM, "unknown status code")
  `TCAB_ASSERT_NOW(a_no_write_zero, out_valid && !write_valid, cell_address == 32'd0 && write_value == 64'd0, "address or value set without a write")
  `TCAB_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "second item taken before the first was done")

endmodule

bind tensor_cell_address_builder tcab_checker u_tcab_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .status       (status),
  .write_valid  (write_valid),
  .cell_address (cell_address),
  .write_value  (write_value)
);
